@@ design/vna_pkg.sv @@
`timescale 1ns / 1ps

package vna_pkg;

    localparam int VERTEX_COUNT = 1024;
    localparam int IDX_W = $clog2(VERTEX_COUNT);
    localparam int POS_W = 16;
    localparam int SUM_W = 22;
    localparam int NRM_W = 16;
    localparam int VEC_W = 36;
    localparam int EDGE_W = POS_W + 1;
    localparam int PROD_W = 2 * EDGE_W;
    localparam int FRAC_BITS = 14;
    localparam int SQ_W = 62;
    localparam int LEN_W = 32;
    localparam int DIV_W = LEN_W + FRAC_BITS;
    localparam int Q_W = FRAC_BITS + 1;

    localparam logic [VEC_W-1:0] NORM_LOW = VEC_W'(1) << 29;
    localparam logic [VEC_W-1:0] NORM_HIGH = VEC_W'(1) << 30;
    localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

    typedef enum logic [1:0] {
        CMD_LOAD = 2'd0,
        CMD_TRI  = 2'd1,
        CMD_READ = 2'd2,
        CMD_NOP  = 2'd3
    } cmd_t;

    typedef struct packed {
        logic [1:0]         cmd;
        logic [9:0]         vertex;
        logic [9:0]         corner_b;
        logic [9:0]         corner_c;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic signed [15:0] pos_z;
    } req_t;

    typedef struct packed {
        logic [9:0]         vertex_out;
        logic signed [15:0] normal_x;
        logic signed [15:0] normal_y;
        logic signed [15:0] normal_z;
        logic               zero_normal;
    } rsp_t;

    typedef struct packed {
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic signed [POS_W-1:0] z;
    } pos3_t;

    typedef struct packed {
        logic signed [SUM_W-1:0] x;
        logic signed [SUM_W-1:0] y;
        logic signed [SUM_W-1:0] z;
    } sum3_t;

    typedef struct packed {
        logic done;
        logic nonzero;
    } norm_stat_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOAD,
        S_TRD_A,
        S_TRD_B,
        S_TRD_C,
        S_TCAP,
        S_TMUL,
        S_NSTART,
        S_NWAIT,
        S_SUM_RD,
        S_SUM_WR,
        S_RD_REQ,
        S_RD_CAP,
        S_OUT
    } state_t;

    typedef enum logic [2:0] {
        N_IDLE,
        N_SHIFT,
        N_SQ,
        N_SQRT,
        N_DLOAD,
        N_DIV,
        N_DONE
    } nstate_t;

    function automatic logic in_range(input logic [9:0] v);
        return (32'(v) < VERTEX_COUNT);
    endfunction

    function automatic logic [IDX_W-1:0] to_idx(input logic [9:0] v);
        return IDX_W'(v);
    endfunction

    function automatic logic signed [SUM_W-1:0] sat_add(input logic signed [SUM_W-1:0] a,
                                                        input logic signed [NRM_W-1:0] b);
        logic signed [SUM_W:0] s;
        s = (SUM_W+1)'(a) + (SUM_W+1)'(b);
        if (s > (SUM_W+1)'(SUM_MAX))
            return SUM_MAX;
        else if (s < (SUM_W+1)'(SUM_MIN))
            return SUM_MIN;
        else
            return s[SUM_W-1:0];
    endfunction

endpackage

@@ design/vertex_normal_accumulator.sv @@
`timescale 1ns / 1ps
// Smooth per-vertex normal builder for a triangle mesh.
// Request channel (req_valid, req_stall, req): one beat per command.
//   Load stores a Q7.8 position and clears the vertex's normal sum.
//   Triangle adds the unit face normal of (b-a)x(c-a) to corners a, b, c.
//   Read returns the normalized sum of one vertex as a Q1.14 unit vector.
// Response channel (rsp_valid, rsp_stall, rsp): one beat per read only.
// One command is in work at a time; req_stall is high until it is done.
// A triangle runs memory reads and the cross product, one normalize pass and,
// if the face normal is nonzero, a sum update at each corner. A normalize
// pass shifts the vector into range, squares and sums its components, takes
// the square root and divides each component by it, all in the one iterative
// normalizer. A read fetches the sum and runs one normalize pass to respond.
// The response sits in an output register; the next command is taken while
// it waits, but a later read holds until the receiver drops rsp_stall.
// Reset clears the sequencer and the response valid; the position and sum
// memories hold nothing defined until each vertex is loaded.
module vertex_normal_accumulator
    import vna_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    state_t state_reg, state_next;
    req_t   item_reg, item_next;
    pos3_t  pa_reg, pa_next;
    pos3_t  pb_reg, pb_next;
    logic [2:0][EDGE_W-1:0] e1_reg, e1_next;
    logic [2:0][EDGE_W-1:0] e2_reg, e2_next;
    logic [2:0][VEC_W-1:0]  vec_reg, vec_next;
    logic signed [PROD_W-1:0] p_reg, p_next;
    logic [2:0] cnt_reg, cnt_next;
    logic [1:0] k_reg, k_next;
    rsp_t rsp_reg, rsp_next;
    rsp_t res_reg, res_next;
    logic rsp_valid_reg, rsp_valid_next;

    logic        pos_we;
    logic [IDX_W-1:0] pos_waddr, pos_raddr;
    pos3_t       pos_wdata, pos_rdata;
    logic        sum_we;
    logic [IDX_W-1:0] sum_waddr, sum_raddr;
    sum3_t       sum_wdata, sum_rdata;
    logic        norm_start;
    norm_stat_t  nstat;
    logic [2:0][NRM_W-1:0] nrm;
    logic        accept;
    logic [9:0]  corner;
    logic signed [EDGE_W-1:0] op_a, op_b;
    logic [1:0]  acc_i;

    vna_ram #(.WIDTH($bits(pos3_t)), .DEPTH(VERTEX_COUNT)) u_pos (
        .clk   (clk),
        .we    (pos_we),
        .waddr (pos_waddr),
        .wdata (pos_wdata),
        .raddr (pos_raddr),
        .rdata (pos_rdata)
    );

    vna_ram #(.WIDTH($bits(sum3_t)), .DEPTH(VERTEX_COUNT)) u_sum (
        .clk   (clk),
        .we    (sum_we),
        .waddr (sum_waddr),
        .wdata (sum_wdata),
        .raddr (sum_raddr),
        .rdata (sum_rdata)
    );

    vna_norm u_norm (
        .clk   (clk),
        .rst_n (rst_n),
        .start (norm_start),
        .vec   (vec_reg),
        .stat  (nstat),
        .nrm   (nrm)
    );

    assign req_stall = (state_reg != S_IDLE);
    assign accept = req_valid && !req_stall;
    assign rsp_valid = rsp_valid_reg;
    assign rsp = rsp_reg;

    always_comb
    begin
        case (k_reg)
            2'd0:    corner = item_reg.vertex;
            2'd1:    corner = item_reg.corner_b;
            default: corner = item_reg.corner_c;
        endcase
    end

    always_comb
    begin
        case (cnt_reg)
            3'd0:    begin op_a = e1_reg[1]; op_b = e2_reg[2]; end
            3'd1:    begin op_a = e1_reg[2]; op_b = e2_reg[1]; end
            3'd2:    begin op_a = e1_reg[2]; op_b = e2_reg[0]; end
            3'd3:    begin op_a = e1_reg[0]; op_b = e2_reg[2]; end
            3'd4:    begin op_a = e1_reg[0]; op_b = e2_reg[1]; end
            default: begin op_a = e1_reg[1]; op_b = e2_reg[0]; end
        endcase
    end

    assign acc_i = 2'((cnt_reg - 3'd1) >> 1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        pa_reg   <= pa_next;
        pb_reg   <= pb_next;
        e1_reg   <= e1_next;
        e2_reg   <= e2_next;
        vec_reg  <= vec_next;
        p_reg    <= p_next;
        cnt_reg  <= cnt_next;
        k_reg    <= k_next;
        rsp_reg  <= rsp_next;
        res_reg  <= res_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        item_next      = item_reg;
        pa_next        = pa_reg;
        pb_next        = pb_reg;
        e1_next        = e1_reg;
        e2_next        = e2_reg;
        vec_next       = vec_reg;
        p_next         = p_reg;
        cnt_next       = cnt_reg;
        k_next         = k_reg;
        rsp_next       = rsp_reg;
        res_next       = res_reg;
        rsp_valid_next = rsp_valid_reg;
        pos_we         = 1'b0;
        pos_waddr      = to_idx(item_reg.vertex);
        pos_wdata      = '{x: item_reg.pos_x, y: item_reg.pos_y, z: item_reg.pos_z};
        pos_raddr      = to_idx(item_reg.vertex);
        sum_we         = 1'b0;
        sum_waddr      = to_idx(corner);
        sum_wdata      = '0;
        sum_raddr      = to_idx(corner);
        norm_start     = 1'b0;

        if (rsp_valid_reg && !rsp_stall)
            rsp_valid_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    item_next = req;
                    k_next = '0;
                    case (cmd_t'(req.cmd))
                        CMD_LOAD:
                            if (in_range(req.vertex))
                                state_next = S_LOAD;
                        CMD_TRI:
                            if (in_range(req.vertex) && in_range(req.corner_b)
                                && in_range(req.corner_c))
                                state_next = S_TRD_A;
                        CMD_READ:
                        begin
                            if (in_range(req.vertex))
                            begin
                                state_next = S_RD_REQ;
                            end
                            else
                            begin
                                res_next = '{vertex_out: req.vertex, normal_x: '0,
                                             normal_y: '0, normal_z: '0, zero_normal: 1'b1};
                                state_next = S_OUT;
                            end
                        end
                        default:
                            state_next = S_IDLE;
                    endcase
                end
            end
            S_LOAD:
            begin
                pos_we = 1'b1;
                sum_we = 1'b1;
                sum_waddr = to_idx(item_reg.vertex);
                sum_wdata = '0;
                state_next = S_IDLE;
            end
            S_TRD_A:
            begin
                pos_raddr = to_idx(item_reg.vertex);
                state_next = S_TRD_B;
            end
            S_TRD_B:
            begin
                pos_raddr = to_idx(item_reg.corner_b);
                pa_next = pos_rdata;
                state_next = S_TRD_C;
            end
            S_TRD_C:
            begin
                pos_raddr = to_idx(item_reg.corner_c);
                pb_next = pos_rdata;
                state_next = S_TCAP;
            end
            S_TCAP:
            begin
                e1_next[0] = EDGE_W'(pb_reg.x) - EDGE_W'(pa_reg.x);
                e1_next[1] = EDGE_W'(pb_reg.y) - EDGE_W'(pa_reg.y);
                e1_next[2] = EDGE_W'(pb_reg.z) - EDGE_W'(pa_reg.z);
                e2_next[0] = EDGE_W'(pos_rdata.x) - EDGE_W'(pa_reg.x);
                e2_next[1] = EDGE_W'(pos_rdata.y) - EDGE_W'(pa_reg.y);
                e2_next[2] = EDGE_W'(pos_rdata.z) - EDGE_W'(pa_reg.z);
                vec_next = '0;
                cnt_next = '0;
                state_next = S_TMUL;
            end
            S_TMUL:
            begin
                p_next = op_a * op_b;
                if (cnt_reg != 3'd0)
                begin
                    if (cnt_reg[0])
                        vec_next[acc_i] = vec_reg[acc_i] + VEC_W'(p_reg);
                    else
                        vec_next[acc_i] = vec_reg[acc_i] - VEC_W'(p_reg);
                end
                cnt_next = cnt_reg + 3'd1;
                if (cnt_reg == 3'd6)
                    state_next = S_NSTART;
            end
            S_NSTART:
            begin
                norm_start = 1'b1;
                state_next = S_NWAIT;
            end
            S_NWAIT:
            begin
                if (nstat.done)
                begin
                    if (cmd_t'(item_reg.cmd) == CMD_READ)
                    begin
                        res_next = '{vertex_out: item_reg.vertex, normal_x: nrm[0],
                                     normal_y: nrm[1], normal_z: nrm[2],
                                     zero_normal: !nstat.nonzero};
                        state_next = S_OUT;
                    end
                    else if (nstat.nonzero)
                    begin
                        state_next = S_SUM_RD;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_SUM_RD:
            begin
                state_next = S_SUM_WR;
            end
            S_SUM_WR:
            begin
                sum_we = 1'b1;
                sum_wdata.x = sat_add(sum_rdata.x, nrm[0]);
                sum_wdata.y = sat_add(sum_rdata.y, nrm[1]);
                sum_wdata.z = sat_add(sum_rdata.z, nrm[2]);
                k_next = k_reg + 2'd1;
                state_next = (k_reg == 2'd2) ? S_IDLE : S_SUM_RD;
            end
            S_RD_REQ:
            begin
                sum_raddr = to_idx(item_reg.vertex);
                state_next = S_RD_CAP;
            end
            S_RD_CAP:
            begin
                vec_next[0] = VEC_W'(sum_rdata.x);
                vec_next[1] = VEC_W'(sum_rdata.y);
                vec_next[2] = VEC_W'(sum_rdata.z);
                state_next = S_NSTART;
            end
            S_OUT:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_next = res_reg;
                    rsp_valid_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

`ifndef NO_ASSERTIONS
    a_zero_flag: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.zero_normal |-> rsp.normal_x == '0 && rsp.normal_y == '0
                                         && rsp.normal_z == '0)
        else $error("zero_normal response carries a nonzero normal");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept && cmd_t'(req.cmd) == CMD_TRI && in_range(req.vertex)
        && in_range(req.corner_b) && in_range(req.corner_c) |=> req_stall)
        else $error("triangle accepted without going busy");

    a_norm_bound: assert property (@(posedge clk) disable iff (!rst_n)
        nstat.done |-> $signed(nrm[0]) <= 16384 && $signed(nrm[0]) >= -16384
                    && $signed(nrm[1]) <= 16384 && $signed(nrm[1]) >= -16384
                    && $signed(nrm[2]) <= 16384 && $signed(nrm[2]) >= -16384)
        else $error("normalizer result out of unit range");

    a_rsp_from_out: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(state_reg) == S_OUT)
        else $error("response raised outside the output step");
`endif

endmodule

@@ design/vna_ram.sv @@
`timescale 1ns / 1ps

module vna_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ design/vna_norm.sv @@
`timescale 1ns / 1ps

module vna_norm
    import vna_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [2:0][VEC_W-1:0]  vec,
    output norm_stat_t             stat,
    output logic [2:0][NRM_W-1:0]  nrm
);

    nstate_t state_reg, state_next;
    logic [2:0][VEC_W-1:0] m_reg, m_next;
    logic [2:0]            sgn_reg, sgn_next;
    logic [1:0]            cnt_reg, cnt_next;
    logic [SQ_W-1:0]       p_reg, p_next;
    logic [SQ_W-1:0]       acc_reg, acc_next;
    logic [SQ_W-1:0]       root_reg, root_next;
    logic [SQ_W-1:0]       bit_reg, bit_next;
    logic [DIV_W-1:0]      rem_reg, rem_next;
    logic [DIV_W-1:0]      d_reg, d_next;
    logic [Q_W-1:0]        q_reg, q_next;
    logic [3:0]            dc_reg, dc_next;
    logic [2:0][NRM_W-1:0] nrm_reg, nrm_next;
    logic                  nz_reg, nz_next;
    logic [VEC_W-1:0]      big;
    logic [SQ_W-1:0]       trial;
    logic [LEN_W-1:0]      len;
    logic [VEC_W-1:0]      mag;

    always_comb
    begin
        big = m_reg[0];
        if (m_reg[1] > big)
            big = m_reg[1];
        if (m_reg[2] > big)
            big = m_reg[2];
    end

    assign trial = root_reg + bit_reg;
    assign len = root_reg[LEN_W-1:0];
    assign mag = m_reg[cnt_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= N_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_reg    <= m_next;
        sgn_reg  <= sgn_next;
        cnt_reg  <= cnt_next;
        p_reg    <= p_next;
        acc_reg  <= acc_next;
        root_reg <= root_next;
        bit_reg  <= bit_next;
        rem_reg  <= rem_next;
        d_reg    <= d_next;
        q_reg    <= q_next;
        dc_reg   <= dc_next;
        nrm_reg  <= nrm_next;
        nz_reg   <= nz_next;
    end

    always_comb
    begin
        state_next = state_reg;
        m_next     = m_reg;
        sgn_next   = sgn_reg;
        cnt_next   = cnt_reg;
        p_next     = p_reg;
        acc_next   = acc_reg;
        root_next  = root_reg;
        bit_next   = bit_reg;
        rem_next   = rem_reg;
        d_next     = d_reg;
        q_next     = q_reg;
        dc_next    = dc_reg;
        nrm_next   = nrm_reg;
        nz_next    = nz_reg;
        case (state_reg)
            N_IDLE:
            begin
                if (start)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        sgn_next[i] = vec[i][VEC_W-1];
                        m_next[i] = vec[i][VEC_W-1] ? (~vec[i] + VEC_W'(1)) : vec[i];
                    end
                    if (vec == '0)
                    begin
                        nz_next = 1'b0;
                        nrm_next = '0;
                        state_next = N_DONE;
                    end
                    else
                    begin
                        nz_next = 1'b1;
                        state_next = N_SHIFT;
                    end
                end
            end
            N_SHIFT:
            begin
                if (big < NORM_LOW)
                begin
                    for (int i = 0; i < 3; i++)
                        m_next[i] = m_reg[i] << 1;
                end
                else if (big >= NORM_HIGH)
                begin
                    for (int i = 0; i < 3; i++)
                        m_next[i] = m_reg[i] >> 1;
                end
                else
                begin
                    cnt_next = '0;
                    acc_next = '0;
                    state_next = N_SQ;
                end
            end
            N_SQ:
            begin
                if (cnt_reg != 2'd3)
                    p_next = SQ_W'(mag[29:0] * mag[29:0]);
                if (cnt_reg != 2'd0)
                    acc_next = acc_reg + p_reg;
                cnt_next = cnt_reg + 2'd1;
                if (cnt_reg == 2'd3)
                begin
                    root_next = '0;
                    bit_next = SQ_W'(1) << 60;
                    state_next = N_SQRT;
                end
            end
            N_SQRT:
            begin
                if (acc_reg >= trial)
                begin
                    acc_next = acc_reg - trial;
                    root_next = (root_reg >> 1) + bit_reg;
                end
                else
                begin
                    root_next = root_reg >> 1;
                end
                bit_next = bit_reg >> 2;
                if (bit_reg == SQ_W'(1))
                begin
                    cnt_next = '0;
                    state_next = N_DLOAD;
                end
            end
            N_DLOAD:
            begin
                rem_next = (DIV_W'(m_reg[cnt_reg]) << FRAC_BITS) + DIV_W'(len >> 1);
                d_next = {len, {FRAC_BITS{1'b0}}};
                q_next = '0;
                dc_next = '0;
                state_next = N_DIV;
            end
            N_DIV:
            begin
                if (rem_reg >= d_reg)
                begin
                    rem_next = rem_reg - d_reg;
                    q_next = {q_reg[Q_W-2:0], 1'b1};
                end
                else
                begin
                    q_next = {q_reg[Q_W-2:0], 1'b0};
                end
                d_next = d_reg >> 1;
                dc_next = dc_reg + 4'd1;
                if (dc_reg == 4'(Q_W - 1))
                begin
                    nrm_next[cnt_reg] = sgn_reg[cnt_reg] ? (~NRM_W'(q_next) + NRM_W'(1))
                                                         : NRM_W'(q_next);
                    if (cnt_reg == 2'd2)
                    begin
                        state_next = N_DONE;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + 2'd1;
                        state_next = N_DLOAD;
                    end
                end
            end
            N_DONE:
            begin
                state_next = N_IDLE;
            end
            default:
            begin
                state_next = N_IDLE;
            end
        endcase
    end

    assign stat.done = (state_reg == N_DONE);
    assign stat.nonzero = nz_reg;
    assign nrm = nrm_reg;

endmodule
